>>> hdl/region_chunk_allocator_macros.svh
// Assertion macros for the region chunk allocator checker.
// Used only by the checker file; needs nothing else.
`ifndef REGION_CHUNK_ALLOCATOR_MACROS_SVH
`define REGION_CHUNK_ALLOCATOR_MACROS_SVH

// same-cycle implication, reset-qualified
`define RCA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset-qualified
`define RCA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rca_pkg.sv
// Shared types and constants of the region chunk allocator.
// No dependencies; used by every RTL file of the block.
package rca_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOSPACE  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_ALIGN = 3'd1;
  localparam logic [2:0] CFG_BASE  = 3'd2;
  localparam logic [2:0] CFG_LEN   = 3'd3;

  // placement modes
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // one table entry
  typedef struct packed {
    logic        taken;
    logic [31:0] length;
    logic [31:0] start;
  } entry_t;

  // operand set for the shared adder
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

endpackage

>>> hdl/region_chunk_allocator.sv
// Region chunk allocator top level: sequencer around the table RAM and shared adder.
// Depends on rca_pkg, rca_ram and rca_alu.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request item: allocate a chunk of
//   in_request_size bytes, or free the chunk starting at in_target_address.
//   Result channel (out_valid/out_ready) returns one item per request with a
//   status, the granted address and the granted size (zero unless granted).
//   cfg_we writes register cfg_index with cfg_wdata; any write to registers 0..3
//   clears the table to the single tail entry before the next item is accepted.
//   Write configuration only while the block is idle.
// Sequencing:
//   One item at a time. On allocate each table entry visited costs a RAM read
//   plus three passes through the shared adder; on free the lookup reads and
//   checks each entry, and a free that merges then shifts each following entry
//   down with a RAM read and a RAM write.
// Reset: synchronous, active low; control registers return to their defaults and the
//   table is cleared to one tail entry in the first idle cycle.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and its own result holds until the output is taken.
module region_chunk_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_target_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_granted_address,
  output logic [31:0] out_granted_size,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int IW = rca_pkg::IDX_W;
  localparam int CW = rca_pkg::CNT_W;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_E_RD   = 4'd1;
  localparam logic [3:0] S_E_C1   = 4'd2;
  localparam logic [3:0] S_E_C2   = 4'd3;
  localparam logic [3:0] S_E_C3   = 4'd4;
  localparam logic [3:0] S_A_TAIL = 4'd5;
  localparam logic [3:0] S_F_RD   = 4'd6;
  localparam logic [3:0] S_F_CHK  = 4'd7;
  localparam logic [3:0] S_F_PRD  = 4'd8;
  localparam logic [3:0] S_F_PCHK = 4'd9;
  localparam logic [3:0] S_F_NRD  = 4'd10;
  localparam logic [3:0] S_F_NCHK = 4'd11;
  localparam logic [3:0] S_F_MRG  = 4'd12;
  localparam logic [3:0] S_SH_RD  = 4'd13;
  localparam logic [3:0] S_SH_WR  = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  logic [3:0]    state_r, state_nxt;

  // configuration
  logic          mode_r, pend_r;
  logic [3:0]    alog_r;
  logic [31:0]   base_r, len_r;

  // request and working registers
  logic          app_r, tk_r;
  logic [31:0]   size_r, tgt_r, s_r, l_r, end_r, al_r, need_r, xs_r;
  logic [CW-1:0] cnt_r, j_r;
  logic [IW-1:0] idx_r, i_r, lo_r;
  logic [1:0]    k_r;

  // pending result and output register
  logic [1:0]    res_status_r, out_status_r;
  logic [31:0]   res_addr_r, res_size_r, out_addr_r, out_size_r;
  logic          out_valid_r;

  // RAM and adder hookup
  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  rca_pkg::entry_t   ram_wdata, q;
  rca_pkg::alu_req_t alu_req;
  logic [31:0]       alu_cmp, alu_sum;
  logic              alu_ge;

  logic [31:0]   amask;
  logic [CW:0]   sh_src;
  logic          more_search, i_has_next, idx_has_next, full;

  rca_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (q)
  );

  rca_alu u_alu (
    .req     (alu_req),
    .cmp_val (alu_cmp),
    .sum     (alu_sum),
    .ge      (alu_ge)
  );

  // derived values
  assign amask        = (32'd1 << alog_r) - 32'd1;
  assign sh_src       = {1'b0, j_r} + {{(CW-1){1'b0}}, k_r};
  assign more_search  = ({1'b0, idx_r} + CW'(2)) < cnt_r;
  assign idx_has_next = ({1'b0, idx_r} + CW'(1)) < cnt_r;
  assign i_has_next   = ({1'b0, i_r} + CW'(1)) < cnt_r;
  assign full         = (cnt_r == CW'(rca_pkg::TABLE_ENTRIES));

  assign in_ready            = (state_r == S_IDLE) && !pend_r;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;
  assign out_granted_size    = out_size_r;

  // adder operand select
  always_comb begin
    alu_req = '{a: s_r, b: amask, sub: 1'b0};
    alu_cmp = end_r;
    unique case (state_r)
      S_E_C1, S_F_CHK, S_F_NCHK: alu_req = '{a: q.start, b: q.length, sub: 1'b0};
      S_E_C3:   alu_req = '{a: al_r, b: size_r, sub: 1'b0};
      S_A_TAIL: alu_req = '{a: end_r, b: need_r, sub: 1'b1};
      S_F_MRG:  alu_req = '{a: end_r, b: xs_r, sub: 1'b1};
      default:  alu_req = '{a: s_r, b: amask, sub: 1'b0};
    endcase
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '{taken: 1'b0, length: len_r, start: base_r};
    ram_raddr = (state_r == S_SH_RD) ? sh_src[IW-1:0] : idx_r;
    unique case (state_r)
      S_IDLE: begin
        ram_we    = pend_r;
        ram_waddr = '0;
      end
      S_E_C3: begin
        if (app_r) begin
          ram_we    = alu_ge && !full;
          ram_wdata = '{taken: 1'b1, length: size_r, start: al_r};
        end else begin
          ram_we    = !tk_r && alu_ge;
          ram_wdata = '{taken: 1'b1, length: l_r, start: s_r};
        end
      end
      S_A_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + IW'(1);
        ram_wdata = '{taken: 1'b0, length: alu_sum, start: need_r};
      end
      S_F_MRG: begin
        ram_we    = 1'b1;
        ram_waddr = lo_r;
        ram_wdata = '{taken: 1'b0, length: alu_sum, start: xs_r};
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[IW-1:0];
        ram_wdata = q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!pend_r && in_valid) begin
          state_nxt = (in_action == rca_pkg::ACT_FREE) ? S_F_RD : S_E_RD;
        end
      end
      S_E_RD: state_nxt = S_E_C1;
      S_E_C1: state_nxt = S_E_C2;
      S_E_C2: state_nxt = S_E_C3;
      S_E_C3: begin
        if (app_r) begin
          if (alu_ge && !full) begin
            state_nxt = S_A_TAIL;
          end else if (mode_r == rca_pkg::MODE_APPEND && cnt_r > CW'(1)) begin
            state_nxt = S_E_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          if (!tk_r && alu_ge) begin
            state_nxt = S_FIN;
          end else if (more_search || mode_r == rca_pkg::MODE_SEARCH) begin
            state_nxt = S_E_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_A_TAIL: state_nxt = S_FIN;
      S_F_RD:   state_nxt = S_F_CHK;
      S_F_CHK: begin
        if (q.start == tgt_r) begin
          if (idx_r != '0) begin
            state_nxt = S_F_PRD;
          end else if (idx_has_next) begin
            state_nxt = S_F_NRD;
          end else begin
            state_nxt = S_F_MRG;
          end
        end else begin
          state_nxt = idx_has_next ? S_F_RD : S_FIN;
        end
      end
      S_F_PRD:  state_nxt = S_F_PCHK;
      S_F_PCHK: state_nxt = i_has_next ? S_F_NRD : S_F_MRG;
      S_F_NRD:  state_nxt = S_F_NCHK;
      S_F_NCHK: state_nxt = S_F_MRG;
      S_F_MRG:  state_nxt = (k_r == 2'd0) ? S_FIN : S_SH_RD;
      S_SH_RD:  state_nxt = (sh_src < {1'b0, cnt_r}) ? S_SH_WR : S_FIN;
      S_SH_WR:  state_nxt = S_SH_RD;
      S_FIN:    state_nxt = (!out_valid_r || out_ready) ? S_IDLE : S_FIN;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b1;
      mode_r      <= rca_pkg::MODE_APPEND;
      alog_r      <= 4'd6;
      base_r      <= '0;
      len_r       <= '0;
      cnt_r       <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // output register: loaded by the sequencer, emptied on accept
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // table clear: requested by a register write, done on the next idle cycle
      if (cfg_we && cfg_index <= rca_pkg::CFG_LEN) begin
        pend_r <= 1'b1;
      end else if (state_r == S_IDLE) begin
        pend_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE:   if (pend_r) begin
          cnt_r <= CW'(1);
        end
        S_A_TAIL: cnt_r <= cnt_r + CW'(1);
        S_SH_RD:  if (!(sh_src < {1'b0, cnt_r})) begin
          cnt_r <= cnt_r - {{(CW-2){1'b0}}, k_r};
        end
        default: ;
      endcase
      // configuration write
      if (cfg_we) begin
        unique case (cfg_index)
          rca_pkg::CFG_MODE:  mode_r <= cfg_wdata[0];
          rca_pkg::CFG_ALIGN: alog_r <= cfg_wdata[3:0];
          rca_pkg::CFG_BASE:  base_r <= cfg_wdata;
          rca_pkg::CFG_LEN:   len_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (!pend_r && in_valid) begin
          size_r <= in_request_size;
          tgt_r  <= in_target_address;
          if (in_action == rca_pkg::ACT_FREE) begin
            idx_r <= '0;
          end else if (mode_r == rca_pkg::MODE_SEARCH && cnt_r > CW'(1)) begin
            idx_r <= '0;
            app_r <= 1'b0;
          end else begin
            idx_r <= IW'(cnt_r - CW'(1));
            app_r <= 1'b1;
          end
        end
      end
      S_E_C1: begin
        s_r   <= q.start;
        l_r   <= q.length;
        tk_r  <= q.taken;
        end_r <= alu_sum;
      end
      S_E_C2: al_r <= alu_sum & ~amask;
      S_E_C3: begin
        need_r <= alu_sum;
        if (app_r) begin
          if (!(alu_ge && !full)) begin
            if (mode_r == rca_pkg::MODE_APPEND && cnt_r > CW'(1)) begin
              idx_r <= '0;
              app_r <= 1'b0;
            end else begin
              res_status_r <= rca_pkg::ST_NOSPACE;
              res_addr_r   <= '0;
              res_size_r   <= '0;
            end
          end
        end else if (!tk_r && alu_ge) begin
          res_status_r <= rca_pkg::ST_DONE;
          res_addr_r   <= s_r;
          res_size_r   <= l_r;
        end else if (more_search) begin
          idx_r <= idx_r + IW'(1);
        end else if (mode_r == rca_pkg::MODE_SEARCH) begin
          idx_r <= IW'(cnt_r - CW'(1));
          app_r <= 1'b1;
        end else begin
          res_status_r <= rca_pkg::ST_NOSPACE;
          res_addr_r   <= '0;
          res_size_r   <= '0;
        end
      end
      S_A_TAIL: begin
        res_status_r <= rca_pkg::ST_DONE;
        res_addr_r   <= al_r;
        res_size_r   <= size_r;
      end
      S_F_CHK: begin
        if (q.start == tgt_r) begin
          end_r <= alu_sum;
          xs_r  <= q.start;
          lo_r  <= idx_r;
          i_r   <= idx_r;
          k_r   <= 2'd0;
          if (idx_r != '0) begin
            idx_r <= idx_r - IW'(1);
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end else if (idx_has_next) begin
          idx_r <= idx_r + IW'(1);
        end else begin
          res_status_r <= rca_pkg::ST_NOTFOUND;
          res_addr_r   <= '0;
          res_size_r   <= '0;
        end
      end
      S_F_PCHK: begin
        if (!q.taken) begin
          xs_r <= q.start;
          lo_r <= idx_r;
          k_r  <= 2'd1;
        end
        idx_r <= i_r + IW'(1);
      end
      S_F_NCHK: begin
        if (!q.taken) begin
          end_r <= alu_sum;
          k_r   <= k_r + 2'd1;
        end
      end
      S_F_MRG: begin
        j_r          <= {1'b0, lo_r} + CW'(1);
        res_status_r <= rca_pkg::ST_DONE;
        res_addr_r   <= '0;
        res_size_r   <= '0;
      end
      S_SH_WR: j_r <= j_r + CW'(1);
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_status_r <= res_status_r;
          out_addr_r   <= res_addr_r;
          out_size_r   <= res_size_r;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/rca_ram.sv
// Chunk table storage: one write port, one registered read port.
// Depends on rca_pkg for the entry type and depth.
module rca_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [rca_pkg::IDX_W-1:0] waddr,
  input  rca_pkg::entry_t          wdata,
  input  logic [rca_pkg::IDX_W-1:0] raddr,
  output rca_pkg::entry_t          rdata
);

  rca_pkg::entry_t mem [rca_pkg::TABLE_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rca_alu.sv
// Shared 32-bit add/subtract unit with an unsigned compare of its result.
// Depends on rca_pkg for the operand struct.
module rca_alu (
  input  rca_pkg::alu_req_t req,
  input  logic [31:0]       cmp_val,
  output logic [31:0]       sum,
  output logic              ge
);

  // wrap-around sum or difference
  assign sum = req.sub ? (req.a - req.b) : (req.a + req.b);
  // cmp_val >= result, unsigned
  assign ge = (cmp_val >= sum);

endmodule

>>> hdl/rca_chk.sv
// Port-level checker for the region chunk allocator, bound to the top level.
// Depends on region_chunk_allocator_macros.svh and rca_pkg.
`include "region_chunk_allocator_macros.svh"

module rca_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_granted_address,
  input logic [31:0] out_granted_size
);

  // a waiting result is not dropped
  `RCA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")

  // only the three defined status codes
  `RCA_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_status <= rca_pkg::ST_NOTFOUND, "bad status")

  // nothing granted unless the status is done
  `RCA_ASSERT_IMP(a_zero_grant, clk, rst_n, out_valid && out_status != rca_pkg::ST_DONE, out_granted_address == 32'd0 && out_granted_size == 32'd0, "grant on failure")

  // one item at a time: busy right after an accept
  `RCA_ASSERT_NXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "accept while busy")

endmodule

bind region_chunk_allocator rca_chk u_rca_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_granted_address (out_granted_address),
  .out_granted_size    (out_granted_size)
);

>>> bench/rca_checker.sv
// Checker for the region chunk allocator: watches both channels, predicts results, compares.
// Depends on rca_pkg; instantiated by tb beside the block.
`timescale 1ns / 100ps

module rca_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_request_size,
  input  logic [31:0] in_target_address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_granted_address,
  input  logic [31:0] out_granted_size,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [31:0] size;
  } grant_t;

  logic        mode_q;
  logic [3:0]  align_q;
  logic [31:0] base_q, len_q;
  logic [31:0] chunk_start [rca_pkg::TABLE_ENTRIES];
  logic [31:0] chunk_len [rca_pkg::TABLE_ENTRIES];
  logic        chunk_used [rca_pkg::TABLE_ENTRIES];
  int          chunk_count;
  grant_t      grants_due[$];

  assign pending = grants_due.size();

  function automatic void wipe_table();
    for (int k = 0; k < rca_pkg::TABLE_ENTRIES; k++) begin
      chunk_start[k] = '0; chunk_len[k] = '0; chunk_used[k] = 1'b0;
    end
    chunk_start[0] = base_q;
    chunk_len[0] = len_q;
    chunk_count = 1;
  endfunction

  function automatic logic [31:0] align_up(logic [31:0] a);
    logic [31:0] m;
    m = 32'd1 << align_q;
    return (a + m - 32'd1) & ~(m - 32'd1);
  endfunction

  function automatic logic fits(int k, logic [31:0] sz);
    logic [31:0] e_end, n_end;
    e_end = chunk_start[k] + chunk_len[k];
    n_end = align_up(chunk_start[k]) + sz;
    return e_end >= n_end;
  endfunction

  function automatic void drop_chunk(int k);
    for (int j = k; j + 1 < chunk_count; j++) begin
      chunk_start[j] = chunk_start[j+1];
      chunk_len[j] = chunk_len[j+1];
      chunk_used[j] = chunk_used[j+1];
    end
    chunk_count--;
    chunk_start[chunk_count] = '0;
    chunk_len[chunk_count] = '0;
    chunk_used[chunk_count] = 1'b0;
  endfunction

  function automatic logic carve_tail(logic [31:0] sz, ref grant_t g);
    int t;
    logic [31:0] t_end, ns;
    t = chunk_count - 1;
    if (!fits(t, sz) || chunk_count >= rca_pkg::TABLE_ENTRIES) return 1'b0;
    t_end = chunk_start[t] + chunk_len[t];
    ns = align_up(chunk_start[t]);
    chunk_start[t] = ns; chunk_len[t] = sz; chunk_used[t] = 1'b1;
    chunk_start[t+1] = ns + sz;
    chunk_len[t+1] = t_end - (ns + sz);
    chunk_used[t+1] = 1'b0;
    chunk_count++;
    g.addr = ns; g.size = sz;
    return 1'b1;
  endfunction

  function automatic logic reuse_free(logic [31:0] sz, ref grant_t g);
    for (int k = 0; k + 1 < chunk_count; k++)
      if (!chunk_used[k] && fits(k, sz)) begin
        chunk_used[k] = 1'b1;
        g.addr = chunk_start[k]; g.size = chunk_len[k];
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic logic release_at(logic [31:0] a);
    int i, x;
    i = 0;
    while (i < chunk_count && chunk_start[i] != a) i++;
    if (i >= chunk_count) return 1'b0;
    chunk_used[i] = 1'b0;
    x = i;
    if (i > 0 && !chunk_used[i-1]) begin
      chunk_len[i-1] = chunk_start[i] + chunk_len[i] - chunk_start[i-1];
      drop_chunk(i);
      x = i - 1;
    end
    if (x + 1 < chunk_count && !chunk_used[x+1]) begin
      chunk_len[x] = chunk_start[x+1] + chunk_len[x+1] - chunk_start[x];
      drop_chunk(x + 1);
    end
    return 1'b1;
  endfunction

  function automatic grant_t predict_grant(logic act, logic [31:0] sz, logic [31:0] a);
    grant_t g;
    logic ok;
    g = '0;
    if (act == rca_pkg::ACT_ALLOC) begin
      if (mode_q == rca_pkg::MODE_APPEND) begin
        ok = carve_tail(sz, g);
        if (!ok) ok = reuse_free(sz, g);
      end else begin
        ok = reuse_free(sz, g);
        if (!ok) ok = carve_tail(sz, g);
      end
      if (!ok) g = '0;
      g.status = ok ? rca_pkg::ST_DONE : rca_pkg::ST_NOSPACE;
    end else begin
      g.status = release_at(a) ? rca_pkg::ST_DONE : rca_pkg::ST_NOTFOUND;
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t e;
    if (!rst_n) begin
      mode_q = rca_pkg::MODE_APPEND; align_q = 4'd6; base_q = '0; len_q = '0;
      wipe_table();
      grants_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rca_pkg::CFG_MODE:  begin mode_q = cfg_wdata[0]; wipe_table(); end
          rca_pkg::CFG_ALIGN: begin align_q = cfg_wdata[3:0]; wipe_table(); end
          rca_pkg::CFG_BASE:  begin base_q = cfg_wdata; wipe_table(); end
          rca_pkg::CFG_LEN:   begin len_q = cfg_wdata; wipe_table(); end
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        grants_due.push_back(predict_grant(in_action, in_request_size, in_target_address));
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result st=%0d addr=%h size=%h", $time,
                   out_status, out_granted_address, out_granted_size);
        end else begin
          e = grants_due.pop_front();
          if (out_status !== e.status) begin
            fail_count++;
            $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          end
          if (out_granted_address !== e.addr) begin
            fail_count++;
            $display("%0t: address exp %h got %h", $time, e.addr, out_granted_address);
          end
          if (out_granted_size !== e.size) begin
            fail_count++;
            $display("%0t: size exp %h got %h", $time, e.size, out_granted_size);
          end
        end
      end
    end
  end
endmodule

>>> bench/tb.sv
// Top of the region chunk allocator bench: clock, reset, stimulus and verdict.
// Depends on rca_pkg, rca_checker and the region_chunk_allocator RTL.
`timescale 1ns / 100ps

module tb;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_action;
  logic [31:0] in_request_size, in_target_address;
  logic        out_valid, out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_granted_address, out_granted_size;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          fail_count, pending;
  logic        calm, hold_off;
  logic [31:0] live_addrs[$];
  logic [31:0] cur_base;

  region_chunk_allocator dut (.*);

  rca_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("tb: errors");
    $finish;
  end

  // receiver: random stalls, one long hold-off while items pile up
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= calm || ($urandom_range(99) >= 21);
    end
  end

  // track granted addresses for useful frees
  always @(posedge clk)
    if (rst_n && out_valid && out_ready && out_status == rca_pkg::ST_DONE
        && out_granted_size != 0 && live_addrs.size() < 64)
      live_addrs.push_back(out_granted_address);

  // valid stays up after an accept until the next item or an idle cycle replaces it
  task automatic send_item(logic act, logic [31:0] sz, logic [31:0] a);
    if (!calm)
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1;
    in_action <= act;
    in_request_size <= sz;
    in_target_address <= a;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == rca_pkg::CFG_BASE) cur_base = v;
    live_addrs.delete();
  endtask

  task automatic free_pick();
    logic [31:0] a;
    int n;
    n = live_addrs.size();
    if (n != 0 && $urandom_range(9) < 8) begin
      n = $urandom_range(n - 1);
      a = live_addrs[n];
      live_addrs.delete(n);
    end else if ($urandom_range(1)) a = cur_base;
    else a = $urandom;
    send_item(rca_pkg::ACT_FREE, $urandom, a);
  endtask

  task automatic random_phase(int n, logic [31:0] max_sz);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 55)
        send_item(rca_pkg::ACT_ALLOC,
                  ($urandom_range(19) == 0) ? $urandom : $urandom_range(max_sz),
                  $urandom);
      else free_pick();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_action = rca_pkg::ACT_ALLOC;
    in_request_size = '0; in_target_address = '0;
    cfg_we = 1'b0; cfg_index = rca_pkg::CFG_MODE; cfg_wdata = '0;
    calm = 1'b1; hold_off = 1'b0; cur_base = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty region, then a small region with corners
    send_item(rca_pkg::ACT_ALLOC, 32'd0, 32'd0);
    send_item(rca_pkg::ACT_ALLOC, 32'd1, 32'd0);
    send_item(rca_pkg::ACT_FREE, 32'd0, 32'd0);
    drain();
    write_reg(rca_pkg::CFG_BASE, 32'h0000_1003);
    write_reg(rca_pkg::CFG_LEN, 32'h0000_1000);
    send_item(rca_pkg::ACT_ALLOC, 32'd16, '0);
    send_item(rca_pkg::ACT_ALLOC, 32'd0, '0);
    send_item(rca_pkg::ACT_ALLOC, 32'd100, '0);
    send_item(rca_pkg::ACT_ALLOC, 32'hFFFF_FFFF, '0);
    send_item(rca_pkg::ACT_FREE, '0, 32'h0000_1040);
    send_item(rca_pkg::ACT_FREE, '0, 32'h0000_1040);
    send_item(rca_pkg::ACT_FREE, '0, 32'hDEAD_BEEF);
    send_item(rca_pkg::ACT_ALLOC, 32'd8, '0);
    send_item(rca_pkg::ACT_FREE, '0, 32'h0000_1080);
    send_item(rca_pkg::ACT_FREE, '0, 32'h0000_1050);
    send_item(rca_pkg::ACT_ALLOC, 32'd4000, '0);
    drain();
    write_reg(rca_pkg::CFG_MODE, {31'd0, rca_pkg::MODE_SEARCH});
    write_reg(rca_pkg::CFG_ALIGN, 32'd15);
    // unused register index: ignored by the block
    write_reg(5, 32'hFFFF_FFFF);
    send_item(rca_pkg::ACT_ALLOC, 32'd4, '0);
    drain();
    write_reg(rca_pkg::CFG_ALIGN, 32'd0);
    write_reg(rca_pkg::CFG_BASE, 32'hFFFF_FF00);
    write_reg(rca_pkg::CFG_LEN, 32'hFFFF_FFFF);
    send_item(rca_pkg::ACT_ALLOC, 32'h200, '0);
    send_item(rca_pkg::ACT_ALLOC, 32'h10, '0);
    send_item(rca_pkg::ACT_FREE, '0, 32'hFFFF_FF00);
    send_item(rca_pkg::ACT_ALLOC, 32'h80, '0);
    drain();

    // long stretch without idling, then a receiver hold-off
    write_reg(rca_pkg::CFG_MODE, {31'd0, rca_pkg::MODE_APPEND});
    write_reg(rca_pkg::CFG_ALIGN, 32'd2);
    write_reg(rca_pkg::CFG_BASE, 32'h0001_0000);
    write_reg(rca_pkg::CFG_LEN, 32'h0000_4000);
    random_phase(60, 32'h200);
    calm = 1'b0;
    hold_off = 1'b1;
    fork
      begin repeat (1500) @(negedge clk); hold_off = 1'b0; end
      random_phase(20, 32'h200);
    join

    // table-full territory: many tiny chunks
    write_reg(rca_pkg::CFG_ALIGN, 32'd0);
    write_reg(rca_pkg::CFG_LEN, 32'h0000_0100);
    for (int i = 0; i < 80; i++) send_item(rca_pkg::ACT_ALLOC, $urandom_range(3), '0);
    random_phase(60, 32'd4);

    // several settings, extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(rca_pkg::CFG_MODE, $urandom_range(1));
      write_reg(rca_pkg::CFG_ALIGN,
                (ph == 0) ? 32'd12 : (ph == 1) ? 32'd0 : $urandom_range(12));
      write_reg(rca_pkg::CFG_BASE,
                (ph == 2) ? 32'hFFFF_F000 : (ph == 3) ? 32'd0 : $urandom);
      write_reg(rca_pkg::CFG_LEN,
                (ph == 4) ? 32'hFFFF_FFFF : (ph == 5) ? 32'd0 : $urandom_range(32'h20000));
      random_phase(55, (ph == 0) ? 32'h3000 : 32'h800);
    end

    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule

>>> files.f
+incdir+hdl
hdl/rca_pkg.sv
hdl/rca_ram.sv
hdl/rca_alu.sv
hdl/region_chunk_allocator.sv
hdl/rca_chk.sv
bench/rca_checker.sv
bench/tb.sv
